FILE: src/afc_pkg.sv
// shared types, constants and weight tables of the window fall classifier
package afc_pkg;

   localparam int WINDOW_DEF = 200;
   localparam int FEATURES   = 6;
   localparam int HIDDEN_ONE = 16;
   localparam int HIDDEN_TWO = 8;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = 2;

   localparam logic [1:0] ACT_STORE = 2'd0;
   localparam logic [1:0] ACT_EVAL  = 2'd1;
   localparam logic [1:0] ACT_ACK   = 2'd2;

   localparam logic [0:0] CSR_CONFIRM = 1'd0;
   localparam logic [0:0] CSR_MARGIN  = 1'd1;

   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_EVAL,
      CMD_ACK,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } cmd_type;

   typedef struct packed {
      logic               decision;
      logic               fall_latched;
      logic               window_full;
      logic signed [15:0] logit_margin;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         confirm_count;
      logic signed [11:0] threshold;
   } csr_type;

   typedef enum logic [3:0] {
      B_IDLE, B_RD, B_SQ, B_ROOT, B_ACC, B_VA, B_VB, B_VC,
      B_VDIV, B_VROOT, B_FST, B_FDIV, B_L1, B_L2, B_L3, B_FIN
   } back_state_type;

   // weight tables, hundredths; table a: layer one, its biases, output layer and biases
   localparam int TAB_LEN = 136;
   localparam int TAB_AW  = 8;
   localparam int OFS_B1  = 96;
   localparam int OFS_WO  = 112;
   localparam int OFS_BO  = 128;
   localparam int OFS_B2  = 128;

   typedef int tab_type [TAB_LEN];

   localparam tab_type TA_H = '{
      42, -13, 27, -35, 18, 9,
      -28, 33, -21, 15, -42, 11,
      19, -31, 24, -17, 36, -8,
      13, 29, -26, 22, -14, 37,
      -19, 8, -33, 41, -12, 25,
      16, -29, 34, -22, 11, -38,
      -24, 18, -15, 32, -27, 13,
      21, -36, 9, -28, 31, -17,
      -11, 26, -34, 19, -23, 14,
      38, -9, 28, -31, 17, -25,
      12, -37, 22, -16, 33, -19,
      8, 41, -13, 29, -24, 15,
      -32, 18, -27, 11, -38, 23,
      26, -14, 31, -9, 37, -22,
      -18, 34, -11, 28, -33, 16,
      14, -26, 38, -17, 21, -35,
      12, -8, 15, -11, 9, -14, 7, -13,
      11, -6, 16, -9, 13, -10, 8, -12,
      45, -45, -38, 38, 42, -42, -35, 35,
      48, -48, -41, 41, 39, -39, -44, 44,
      15, -15,
      0, 0, 0, 0, 0, 0
   };

   localparam tab_type TB_H = '{
      31, -18, 24, -27, 15, -33, 21, -19,
      -14, 29, -22, 17, -31, 12, -26, 23,
      18, -25, 33, -16, 22, -29, 14, -21,
      -27, 16, -19, 34, -12, 28, -23, 15,
      22, -31, 18, -24, 29, -15, 26, -17,
      -19, 14, -33, 21, -28, 16, -12, 32,
      25, -22, 17, -29, 13, -34, 19, -16,
      -23, 31, -14, 27, -18, 24, -32, 11,
      16, -28, 22, -13, 34, -19, 25, -21,
      -31, 17, -26, 14, -23, 32, -15, 29,
      13, -24, 31, -18, 27, -22, 16, -34,
      -28, 19, -15, 33, -11, 26, -29, 18,
      27, -16, 23, -31, 14, -25, 33, -18,
      -22, 34, -12, 28, -19, 15, -27, 21,
      19, -33, 14, -26, 31, -17, 24, -22,
      -15, 28, -32, 13, -24, 33, -18, 26,
      9, -11, 13, -7, 14, -9, 11, -12
   };

   // q10 of a hundredths value, nearest, half away from zero
   function automatic int q10(int h);
      int v;
      if (h >= 0) begin
         v = (h * 1024 + 50) / 100;
      end else begin
         v = -((-h * 1024 + 50) / 100);
      end
      return v;
   endfunction

   function automatic tab_type mk_q(tab_type h);
      tab_type t;
      for (int k = 0; k < TAB_LEN; k++) begin
         t[k] = q10(h[k]);
      end
      return t;
   endfunction

   localparam tab_type TA_Q = mk_q(TA_H);
   localparam tab_type TB_Q = mk_q(TB_H);
   localparam int      BD_Q = TA_Q[OFS_BO + 1] - TA_Q[OFS_BO];

   // relu, round q22 to q12, saturate
   function automatic logic signed [15:0] relu_q12(logic signed [31:0] acc);
      logic signed [31:0] r;
      logic signed [15:0] y;
      r = (acc + 32'sd512) >>> 10;
      if (acc <= 32'sd0) begin
         y = 16'sd0;
      end else if (r > 32'sd32767) begin
         y = 16'sd32767;
      end else begin
         y = r[15:0];
      end
      return y;
   endfunction

endpackage

FILE: src/accel_window_fall_classifier_core.sv
// top level of the window fall classifier: front queue, back engine, config registers
//
// items go into a four deep command queue (req_push while req_full is low) and
// results come out of a one entry result register (rsp_pop while rsp_empty is
// low). a store, acknowledge or unused action is taken from the queue in the
// cycle after its push, as long as the back is idle and the result register is
// free or being popped, and its result is registered as it is taken. an evaluate
// on a full window walks the sample ring once; for each sample it does one ring
// read, three squaring steps, a bit serial square root and one accumulate, then
// runs seven divisions by constants, each a reciprocal multiply of four partial
// products, one more square root and 232 serial multiply-adds of the network.
// the back works one command at a time and a waiting result holds it off; the
// queue keeps taking items meanwhile until it holds four.
// the sample ring is not cleared: evaluate only runs once WINDOW samples exist.
module accel_window_fall_classifier_core
   import afc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_decision,
   output logic               rsp_fall_latched,
   output logic               rsp_window_full,
   output logic signed [15:0] rsp_logit_margin,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [11:0]        csr_data
);

   // config registers
   logic [7:0]         cc_ff;
   logic signed [11:0] thr_ff;
   csr_type            csr;

   // front to back command path
   cmd_type cmd;
   logic    cmd_valid, cmd_pop;

   // result register
   rsp_type rsp;
   logic    rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff  <= 8'd3;
         thr_ff <= 12'sd217;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CONFIRM: cc_ff  <= csr_data[7:0];
            CSR_MARGIN:  thr_ff <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   assign csr = '{cc_ff, thr_ff};

   // accepts items and decodes actions into queued commands
   afc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_action  (req_action),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .cmd         (cmd),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop)
   );

   // executes commands, owns the ring, the statistics and the fall latch
   afc_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .csr       (csr),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty        = !rsp_valid;
   assign rsp_decision     = rsp.decision;
   assign rsp_fall_latched = rsp.fall_latched;
   assign rsp_window_full  = rsp.window_full;
   assign rsp_logit_margin = rsp.logit_margin;

`ifndef NO_ASSERTIONS
   // the back only takes a command that the queue holds
   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from empty queue");

   // a confirmed fall is always latched in the same item
   a_dec_latch : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_decision) |-> rsp_fall_latched)
      else $error("decision without latched fall");

   // a fall can only be confirmed on a full window
   a_dec_full : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_decision) |-> rsp_window_full)
      else $error("decision before window full");

   // a waiting result is not replaced before it is taken
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp)))
      else $error("waiting result changed");
`endif

endmodule

FILE: src/afc_front.sv
// front: takes items, decodes the action, and queues commands for the back
module afc_front
   import afc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output cmd_type            cmd,
   output logic               cmd_valid,
   input  logic               cmd_pop
);

   cmd_type              q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CMDQ_AW:0]     cnt_ff, cnt_in;
   cmd_type              dec;
   logic                 push_ok, pop_ok;

   always_comb begin
      dec.x = req_accel_x;
      dec.y = req_accel_y;
      dec.z = req_accel_z;
      case (req_action)
         ACT_STORE: dec.kind = CMD_STORE;
         ACT_EVAL:  dec.kind = CMD_EVAL;
         ACT_ACK:   dec.kind = CMD_ACK;
         default:   dec.kind = CMD_NOP;
      endcase
   end

   assign req_full  = (cnt_ff == (CMDQ_AW+1)'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wp_in  = push_ok ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop_ok ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (CMDQ_AW+1)'(push_ok) - (CMDQ_AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wp_ff] <= dec;
      end
   end

endmodule

FILE: src/afc_isqrt.sv
// integer square root of a 32 bit value, one result bit per cycle
module afc_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        busy,
   output logic [15:0] root
);

   logic [31:0] v_ff, v_in, r_ff, r_in, b, t;
   logic [3:0]  k_ff, k_in;
   logic        busy_ff, busy_in;

   always_comb begin
      b       = 32'd1 << {k_ff, 1'b0};
      t       = r_ff + b;
      v_in    = v_ff;
      r_in    = r_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      if (start) begin
         v_in    = value;
         r_in    = '0;
         k_in    = 4'd15;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= t) begin
            v_in = v_ff - t;
            r_in = (r_ff >> 1) + b;
         end else begin
            r_in = r_ff >> 1;
         end
         k_in = k_ff - 1'b1;
         if (k_ff == 4'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
      k_ff <= k_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[15:0];

endmodule

FILE: src/afc_div.sv
// unsigned division by a constant through its reciprocal, summing four partial products in turn
module afc_div #(
   parameter int DIV_W = 48,
   parameter int RC_W  = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [RC_W-1:0]  recip,
   input  logic [7:0]       shift,
   output logic             busy,
   output logic [DIV_W-1:0] quot
);

   localparam int HN = (DIV_W + 1) / 2;
   localparam int HM = (RC_W + 1) / 2;
   localparam int PW = 2 * HN + 2 * HM;

   logic [2*HN-1:0]  n_ff, n_in;
   logic [2*HM-1:0]  m_ff, m_in;
   logic [7:0]       sh_ff, sh_in;
   logic [PW-1:0]    p_ff, p_in, pp_ext;
   logic [2:0]       step_ff, step_in;
   logic [1:0]       k;
   logic [HN-1:0]    a;
   logic [HM-1:0]    b;
   logic [HN+HM-1:0] pp;

   always_comb begin
      // one half of the dividend times one half of the reciprocal per cycle
      k       = 2'(step_ff - 3'd1);
      a       = k[1] ? n_ff[2*HN-1:HN] : n_ff[HN-1:0];
      b       = k[0] ? m_ff[2*HM-1:HM] : m_ff[HM-1:0];
      pp      = a * b;
      pp_ext  = PW'(pp) << ((k[1] ? HN : 0) + (k[0] ? HM : 0));
      n_in    = n_ff;
      m_in    = m_ff;
      sh_in   = sh_ff;
      p_in    = p_ff;
      step_in = step_ff;
      if (start) begin
         n_in    = (2*HN)'(dividend);
         m_in    = (2*HM)'(recip);
         sh_in   = shift;
         p_in    = '0;
         step_in = 3'd4;
      end else if (step_ff != 3'd0) begin
         p_in    = p_ff + pp_ext;
         step_in = step_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff  <= n_in;
      m_ff  <= m_in;
      sh_ff <= sh_in;
      p_ff  <= p_in;
   end

   assign busy = (step_ff != 3'd0);
   assign quot = DIV_W'(p_ff >> sh_ff);

endmodule

FILE: src/afc_back.sv
// back: sample ring, window statistics, feature scaling, network and run latch
module afc_back
   import afc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  csr_type csr,
   output rsp_type rsp,
   output logic    rsp_valid,
   input  logic    rsp_pop
);

   localparam int CW    = $clog2(WINDOW + 1);
   localparam int IW    = $clog2(WINDOW);
   localparam int SUM_W = 16 + CW;
   localparam int SQ_W  = 32 + CW;
   localparam int PA_W  = 32 + 2 * CW;
   localparam int DIV_W = PA_W;
   localparam int RC_W  = DIV_W + 1;
   localparam int DZ_W  = SUM_W + 5;

   // ceiling of 2^(DIV_W + clog2(d)) / d, exact floor quotient for any DIV_W bit dividend
   function automatic logic [RC_W-1:0] recip_of(int d);
      logic [127:0] num;
      num = (128'd1 << (DIV_W + $clog2(d))) + 128'(d - 1);
      return RC_W'(num / 128'(d));
   endfunction

   function automatic logic [7:0] shift_of(int d);
      return 8'(DIV_W + $clog2(d));
   endfunction

   localparam logic [RC_W-1:0] RC_VAR    = recip_of(WINDOW * WINDOW);
   localparam logic [7:0]      SH_VAR    = shift_of(WINDOW * WINDOW);
   localparam logic [RC_W-1:0] RC_MEAN   = recip_of(20 * WINDOW);
   localparam logic [7:0]      SH_MEAN   = shift_of(20 * WINDOW);
   localparam logic [RC_W-1:0] RC_DZ     = recip_of(100 * WINDOW);
   localparam logic [7:0]      SH_DZ     = shift_of(100 * WINDOW);
   localparam logic [RC_W-1:0] RC_TEN    = recip_of(10);
   localparam logic [7:0]      SH_TEN    = shift_of(10);
   localparam logic [RC_W-1:0] RC_THIRTY = recip_of(30);
   localparam logic [7:0]      SH_THIRTY = shift_of(30);
   localparam logic signed [DZ_W-1:0] GOFF = DZ_W'(25088 * WINDOW);

   // sample ring
   logic [47:0]    mem [WINDOW];
   logic [47:0]    rd_ff;
   logic           mem_we;

   back_state_type state_ff, state_in;
   logic [IW-1:0]  wi_ff, wi_in, idx_ff, idx_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic           full_ff, full_in, fall_ff, fall_in, neg_ff, neg_in;
   logic [7:0]     run_ff, run_in, run_nx, cc_eff;
   logic [3:0]     i_ff, i_in, j_ff, j_in;
   logic [31:0]    sq_ff, sq_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]  sumsq_ff, sumsq_in;
   logic [15:0]      mx_ff, mx_in, mn_ff, mn_in;
   logic signed [15:0] axm_ff, axm_in;
   logic signed [SUM_W-1:0] azs_ff, azs_in;
   logic [PA_W-1:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic signed [15:0] f_ff [FEATURES], f_in [FEATURES];
   logic signed [15:0] h1_ff [HIDDEN_ONE], h1_in [HIDDEN_ONE];
   logic signed [15:0] h2_ff [HIDDEN_TWO], h2_in [HIDDEN_TWO];
   logic signed [31:0] acc_ff, acc_in, base, mr;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in, rsp_load;

   // datapath helpers
   logic signed [15:0] op, a_sel, marg, thr16;
   logic signed [31:0] sqp;
   logic [31:0]        msq;
   logic signed [11:0] w_sel, b_sel;
   logic signed [27:0] prod;
   logic [TAB_AW-1:0]  wa_idx, wb_idx;
   logic signed [20:0] axn;
   logic [20:0]        ax_mag;
   logic signed [DZ_W-1:0] dz_s;
   logic [DZ_W-1:0]    dz_mag;
   logic [DIV_W-1:0]   q;
   logic signed [15:0] fval;

   logic               sq_start, sq_busy;
   logic [31:0]        sq_value;
   logic [15:0]        sq_root;
   logic               div_start, div_busy;
   logic [DIV_W-1:0]   div_n, div_q;
   logic [RC_W-1:0]    div_m;
   logic [7:0]         div_s;

   afc_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   afc_div #(
      .DIV_W (DIV_W),
      .RC_W  (RC_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .recip    (div_m),
      .shift    (div_s),
      .busy     (div_busy),
      .quot     (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      wi_in        = wi_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      full_in      = full_ff;
      fall_in      = fall_ff;
      run_in       = run_ff;
      neg_in       = neg_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      axm_in       = axm_ff;
      azs_in       = azs_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      f_in         = f_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      sq_start     = 1'b0;
      sq_value     = sq_in;
      div_start    = 1'b0;
      div_n        = '0;
      div_m        = RC_TEN;
      div_s        = SH_TEN;

      op     = 16'sd0;
      sqp    = 32'sd0;
      msq    = 32'd0;
      a_sel  = 16'sd0;
      w_sel  = 12'sd0;
      b_sel  = 12'sd0;
      wa_idx = '0;
      wb_idx = '0;
      base   = 32'sd0;
      prod   = 28'sd0;
      axn    = (21'(axm_ff) <<< 4) + 21'sd5;
      ax_mag = axn[20] ? 21'(21'sd9 - axn) : 21'(axn);
      dz_s   = (DZ_W'(azs_ff) <<< 3) + (DZ_W'(azs_ff) <<< 1) - GOFF;
      dz_mag = dz_s[DZ_W-1] ? DZ_W'(-dz_s) : DZ_W'(dz_s);
      q      = div_q;
      fval   = 16'sd0;
      mr     = (acc_ff + 32'sd8192) >>> 14;
      marg   = 16'sd0;
      thr16  = 16'(csr.threshold);
      run_nx = (run_ff == 8'hff) ? run_ff : run_ff + 8'd1;
      cc_eff = (csr.confirm_count == 8'd0) ? 8'd1 : csr.confirm_count;

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid && (!rsp_valid_ff || rsp_pop)) begin
               cmd_pop = 1'b1;
               rsp_in  = '{1'b0, fall_ff, full_ff, 16'sd0};
               case (cmd.kind)
                  CMD_STORE: begin
                     mem_we  = 1'b1;
                     wi_in   = (wi_ff == IW'(WINDOW - 1)) ? '0 : wi_ff + 1'b1;
                     fill_in = (fill_ff == CW'(WINDOW)) ? fill_ff : fill_ff + 1'b1;
                     full_in = (fill_in == CW'(WINDOW));
                     rsp_in.window_full = full_in;
                     rsp_load = 1'b1;
                  end
                  CMD_EVAL: begin
                     if (full_ff) begin
                        idx_in   = '0;
                        state_in = B_RD;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  CMD_ACK: begin
                     fall_in = 1'b0;
                     run_in  = 8'd0;
                     rsp_in.fall_latched = 1'b0;
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         B_RD: begin
            j_in     = 4'd0;
            state_in = B_SQ;
         end
         B_SQ: begin
            case (j_ff[1:0])
               2'd0:    op = rd_ff[47:32];
               2'd1:    op = rd_ff[31:16];
               default: op = rd_ff[15:0];
            endcase
            sqp   = op * op;
            sq_in = ((j_ff == 4'd0) ? 32'd0 : sq_ff) + 32'(unsigned'(sqp));
            if (j_ff == 4'd0) begin
               if (idx_ff == '0 || $signed(rd_ff[47:32]) > axm_ff) begin
                  axm_in = rd_ff[47:32];
               end
               azs_in = ((idx_ff == '0) ? SUM_W'(0) : azs_ff)
                        + SUM_W'($signed(rd_ff[15:0]));
            end
            if (j_ff == 4'd2) begin
               sq_start = 1'b1;
               sq_value = sq_in;
               state_in = B_ROOT;
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         B_ROOT: begin
            if (!sq_busy) begin
               state_in = B_ACC;
            end
         end
         B_ACC: begin
            msq      = sq_root * sq_root;
            sum_in   = ((idx_ff == '0) ? SUM_W'(0) : sum_ff) + SUM_W'(sq_root);
            sumsq_in = ((idx_ff == '0) ? SQ_W'(0) : sumsq_ff) + SQ_W'(msq);
            if (idx_ff == '0 || sq_root > mx_ff) begin
               mx_in = sq_root;
            end
            if (idx_ff == '0 || sq_root < mn_ff) begin
               mn_in = sq_root;
            end
            if (idx_ff == IW'(WINDOW - 1)) begin
               state_in = B_VA;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = B_RD;
            end
         end
         B_VA: begin
            pa_in    = PA_W'(sumsq_ff) * PA_W'(WINDOW);
            state_in = B_VB;
         end
         B_VB: begin
            pb_in    = PA_W'(sum_ff) * PA_W'(sum_ff);
            state_in = B_VC;
         end
         B_VC: begin
            div_start = 1'b1;
            div_n     = DIV_W'(pa_ff - pb_ff);
            div_m     = RC_VAR;
            div_s     = SH_VAR;
            state_in  = B_VDIV;
         end
         B_VDIV: begin
            if (!div_busy) begin
               sq_start = 1'b1;
               sq_value = div_q[31:0];
               state_in = B_VROOT;
            end
         end
         B_VROOT: begin
            if (!sq_busy) begin
               i_in     = 4'd0;
               state_in = B_FST;
            end
         end
         B_FST: begin
            neg_in    = 1'b0;
            div_start = 1'b1;
            case (i_ff[2:0])
               3'd0: begin
                  div_n = (DIV_W'(mx_ff) << 3) + DIV_W'(5);
                  div_m = RC_TEN;
                  div_s = SH_TEN;
               end
               3'd1: begin
                  div_n = (DIV_W'(sum_ff) << 5) + DIV_W'(10 * WINDOW);
                  div_m = RC_MEAN;
                  div_s = SH_MEAN;
               end
               3'd2: begin
                  div_n = (DIV_W'(sq_root) << 5) + DIV_W'(5);
                  div_m = RC_TEN;
                  div_s = SH_TEN;
               end
               3'd3: begin
                  neg_in = axn[20];
                  div_n  = DIV_W'(ax_mag);
                  div_m  = RC_TEN;
                  div_s  = SH_TEN;
               end
               3'd4: begin
                  div_n = (DIV_W'(dz_mag) << 5) + DIV_W'(50 * WINDOW);
                  div_m = RC_DZ;
                  div_s = SH_DZ;
               end
               default: begin
                  div_n = (DIV_W'(mx_ff - mn_ff) << 5) + DIV_W'(15);
                  div_m = RC_THIRTY;
                  div_s = SH_THIRTY;
               end
            endcase
            state_in = B_FDIV;
         end
         B_FDIV: begin
            if (!div_busy) begin
               if (neg_ff) begin
                  fval = (q > DIV_W'(32768)) ? -16'sd32768 : $signed(16'd0 - q[15:0]);
               end else begin
                  fval = (q > DIV_W'(32767)) ? 16'sd32767 : $signed(q[15:0]);
               end
               f_in[i_ff[2:0]] = fval;
               if (i_ff == 4'(FEATURES - 1)) begin
                  i_in     = 4'd0;
                  j_in     = 4'd0;
                  state_in = B_L1;
               end else begin
                  i_in     = i_ff + 4'd1;
                  state_in = B_FST;
               end
            end
         end
         B_L1: begin
            wa_idx = {1'b0, j_ff[2:0], i_ff};
            wb_idx = TAB_AW'(OFS_B1) + TAB_AW'(i_ff);
            w_sel  = 12'(TA_Q[wa_idx]);
            b_sel  = 12'(TA_Q[wb_idx]);
            a_sel  = f_ff[j_ff[2:0]];
            prod   = a_sel * w_sel;
            base   = (j_ff == 4'd0) ? (32'(b_sel) <<< 12) : acc_ff;
            acc_in = base + 32'(prod);
            if (j_ff == 4'(FEATURES - 1)) begin
               h1_in[i_ff] = relu_q12(acc_in);
               j_in = 4'd0;
               if (i_ff == 4'(HIDDEN_ONE - 1)) begin
                  i_in     = 4'd0;
                  state_in = B_L2;
               end else begin
                  i_in = i_ff + 4'd1;
               end
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         B_L2: begin
            wa_idx = {1'b0, j_ff, i_ff[2:0]};
            wb_idx = TAB_AW'(OFS_B2) + TAB_AW'(i_ff[2:0]);
            w_sel  = 12'(TB_Q[wa_idx]);
            b_sel  = 12'(TB_Q[wb_idx]);
            a_sel  = h1_ff[j_ff];
            prod   = a_sel * w_sel;
            base   = (j_ff == 4'd0) ? (32'(b_sel) <<< 12) : acc_ff;
            acc_in = base + 32'(prod);
            if (j_ff == 4'(HIDDEN_ONE - 1)) begin
               h2_in[i_ff[2:0]] = relu_q12(acc_in);
               j_in = 4'd0;
               if (i_ff == 4'(HIDDEN_TWO - 1)) begin
                  i_in     = 4'd0;
                  state_in = B_L3;
               end else begin
                  i_in = i_ff + 4'd1;
               end
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         B_L3: begin
            // fall minus no-fall in one pass: differenced weights and bias
            wa_idx = TAB_AW'(OFS_WO) + {4'd0, j_ff[2:0], 1'b1};
            wb_idx = TAB_AW'(OFS_WO) + {4'd0, j_ff[2:0], 1'b0};
            w_sel  = 12'(TA_Q[wa_idx]) - 12'(TA_Q[wb_idx]);
            b_sel  = 12'(BD_Q);
            a_sel  = h2_ff[j_ff[2:0]];
            prod   = a_sel * w_sel;
            base   = (j_ff == 4'd0) ? (32'(b_sel) <<< 12) : acc_ff;
            acc_in = base + 32'(prod);
            if (j_ff == 4'(HIDDEN_TWO - 1)) begin
               state_in = B_FIN;
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         B_FIN: begin
            if (mr > 32'sd32767) begin
               marg = 16'sd32767;
            end else if (mr < -32'sd32768) begin
               marg = -16'sd32768;
            end else begin
               marg = mr[15:0];
            end
            rsp_in = '{1'b0, fall_ff, full_ff, marg};
            if (marg > thr16) begin
               run_in = run_nx;
               if (run_nx >= cc_eff) begin
                  fall_in = 1'b1;
                  rsp_in.decision     = 1'b1;
                  rsp_in.fall_latched = 1'b1;
               end
            end else begin
               run_in = 8'd0;
            end
            rsp_load = 1'b1;
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wi_ff        <= '0;
         fill_ff      <= '0;
         full_ff      <= 1'b0;
         fall_ff      <= 1'b0;
         run_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wi_ff        <= wi_in;
         fill_ff      <= fill_in;
         full_ff      <= full_in;
         fall_ff      <= fall_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      neg_ff   <= neg_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
      sumsq_ff <= sumsq_in;
      mx_ff    <= mx_in;
      mn_ff    <= mn_in;
      axm_ff   <= axm_in;
      azs_ff   <= azs_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      f_ff     <= f_in;
      h1_ff    <= h1_in;
      h2_ff    <= h2_in;
      acc_ff   <= acc_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wi_ff] <= {cmd.x, cmd.y, cmd.z};
      end
      rd_ff <= mem[idx_ff];
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
